// ----- design/clex_pkg.sv -----
// Shared types and constants for the C-style token lexer.
// Holds the token record, lexer mode codes, token kind codes and keyword tables.
// No dependencies.
`default_nettype none

package clex_pkg;

    // One token word as it leaves the block
    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [15:0] length;
        logic        last;
    } tok_t;

    // Lexer modes between bytes
    typedef enum logic [3:0] {
        MODE_IDLE       = 4'd0,
        MODE_SLASH      = 4'd1,
        MODE_LINE       = 4'd2,
        MODE_BLOCK      = 4'd3,
        MODE_BLOCK_STAR = 4'd4,
        MODE_MINUS      = 4'd5,
        MODE_IDENT      = 4'd6,
        MODE_NUMBER     = 4'd7,
        MODE_STRING     = 4'd8,
        MODE_STRING_ESC = 4'd9,
        MODE_CHAR_TEXT  = 4'd10,
        MODE_CHAR_SKIP  = 4'd11
    } lex_mode_t;

    // Token kinds
    localparam logic [5:0] KIND_IDENT    = 6'd0;
    localparam logic [5:0] KIND_LPAREN   = 6'd1;
    localparam logic [5:0] KIND_RPAREN   = 6'd2;
    localparam logic [5:0] KIND_LBRACKET = 6'd3;
    localparam logic [5:0] KIND_RBRACKET = 6'd4;
    localparam logic [5:0] KIND_LBRACE   = 6'd5;
    localparam logic [5:0] KIND_RBRACE   = 6'd6;
    localparam logic [5:0] KIND_COLON    = 6'd7;
    localparam logic [5:0] KIND_SEMI     = 6'd8;
    localparam logic [5:0] KIND_STRING   = 6'd9;
    localparam logic [5:0] KIND_STAR     = 6'd10;
    localparam logic [5:0] KIND_NUMBER   = 6'd11;
    localparam logic [5:0] KIND_PLUS     = 6'd12;
    localparam logic [5:0] KIND_MINUS    = 6'd13;
    localparam logic [5:0] KIND_SLASH    = 6'd15;
    localparam logic [5:0] KIND_DOT      = 6'd16;
    localparam logic [5:0] KIND_PERCENT  = 6'd17;
    localparam logic [5:0] KIND_COMMA    = 6'd18;
    localparam logic [5:0] KIND_LESS     = 6'd19;
    localparam logic [5:0] KIND_GREATER  = 6'd20;
    localparam logic [5:0] KIND_EQUAL    = 6'd21;
    localparam logic [5:0] KIND_AMP      = 6'd22;
    localparam logic [5:0] KIND_PIPE     = 6'd23;
    localparam logic [5:0] KIND_TILDE    = 6'd24;
    localparam logic [5:0] KIND_HASH     = 6'd25;
    localparam logic [5:0] KIND_CHAR     = 6'd26;
    localparam logic [5:0] KIND_ARROW    = 6'd27;
    localparam logic [5:0] KIND_STRUCT   = 6'd28;
    localparam logic [5:0] KIND_CLASS    = 6'd29;
    localparam logic [5:0] KIND_ENUM     = 6'd30;
    localparam logic [5:0] KIND_END      = 6'd31;
    localparam logic [5:0] KIND_UNKNOWN  = 6'd32;

    // Keyword slots: 0 class, 1 struct, 2 enum
    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] r;
        case (k)
            2'd0:    r = 3'd5;
            2'd1:    r = 3'd6;
            2'd2:    r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] kw_kind(input logic [1:0] k);
        logic [5:0] r;
        case (k)
            2'd0:    r = KIND_CLASS;
            2'd1:    r = KIND_STRUCT;
            2'd2:    r = KIND_ENUM;
            default: r = KIND_IDENT;
        endcase
        return r;
    endfunction

    // Character of keyword k at position idx
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
        logic [47:0] txt;
        logic [7:0]  r;
        case (k)
            2'd0:    txt = {8'h00, "class"};
            2'd1:    txt = "struct";
            2'd2:    txt = {16'h0000, "enum"};
            default: txt = '0;
        endcase
        // text is stored first character in the high byte of its length
        case (kw_len(k) - idx)
            3'd1:    r = txt[7:0];
            3'd2:    r = txt[15:8];
            3'd3:    r = txt[23:16];
            3'd4:    r = txt[31:24];
            3'd5:    r = txt[39:32];
            3'd6:    r = txt[47:40];
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/clex_step.sv -----
// Next-state and token logic for one source byte of the lexer.
// Purely combinational; uses clex_pkg for modes, kinds and keyword tables.
`default_nettype none

module clex_step #(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16
) (
    input  logic [7:0]                byte_in,
    input  clex_pkg::lex_mode_t       mode,
    input  logic [POSITION_BITS-1:0]  pos,
    input  logic [POSITION_BITS-1:0]  ots,
    input  logic [LENGTH_BITS-1:0]    otl,
    input  logic [2:0]                kw,
    input  logic [1:0]                nf,
    output clex_pkg::lex_mode_t       mode_next,
    output logic [POSITION_BITS-1:0]  ots_next,
    output logic [LENGTH_BITS-1:0]    otl_next,
    output logic [2:0]                kw_next,
    output logic [1:0]                nf_next,
    output logic                      end_seen,
    output logic [1:0]                res_cnt,
    output clex_pkg::tok_t            tok0,
    output clex_pkg::tok_t            tok1
);
    import clex_pkg::*;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_F  = 8'h66;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    function automatic logic is_alpha(input logic [7:0] ch);
        return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= 8'h30 && ch <= 8'h39;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] v);
        return (v == LEN_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [5:0] punct_kind(input logic [7:0] ch);
        logic [5:0] r;
        case (ch)
            8'h28:   r = KIND_LPAREN;
            8'h29:   r = KIND_RPAREN;
            8'h5B:   r = KIND_LBRACKET;
            8'h5D:   r = KIND_RBRACKET;
            8'h7B:   r = KIND_LBRACE;
            8'h7D:   r = KIND_RBRACE;
            8'h3A:   r = KIND_COLON;
            8'h3B:   r = KIND_SEMI;
            8'h2A:   r = KIND_STAR;
            8'h2B:   r = KIND_PLUS;
            8'h2E:   r = KIND_DOT;
            8'h25:   r = KIND_PERCENT;
            8'h2C:   r = KIND_COMMA;
            8'h3C:   r = KIND_LESS;
            8'h3E:   r = KIND_GREATER;
            8'h3D:   r = KIND_EQUAL;
            8'h26:   r = KIND_AMP;
            8'h7C:   r = KIND_PIPE;
            8'h7E:   r = KIND_TILDE;
            8'h23:   r = KIND_HASH;
            default: r = KIND_UNKNOWN;
        endcase
        return r;
    endfunction

    // Drop keyword candidates that the next identifier character rules out
    function automatic logic [2:0] kw_filter(input logic [2:0] cand,
                                             input logic [LENGTH_BITS-1:0] len,
                                             input logic [7:0] ch);
        logic [2:0]  r;
        logic [31:0] len32;
        r = cand;
        len32 = 32'(len);
        for (int k = 0; k < 3; k++) begin
            if (cand[k]) begin
                if (len32 >= 32'(kw_len(2'(k))) || kw_char(2'(k), len[2:0]) != ch)
                    r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [5:0] ident_kind(input logic [2:0] cand,
                                              input logic [LENGTH_BITS-1:0] len);
        logic [5:0] r;
        r = KIND_IDENT;
        for (int k = 0; k < 3; k++) begin
            if (cand[k] && 32'(len) == 32'(kw_len(2'(k))))
                r = kw_kind(2'(k));
        end
        return r;
    endfunction

    function automatic tok_t mk_tok(input logic [5:0] k,
                                    input logic [POSITION_BITS-1:0] s,
                                    input logic [LENGTH_BITS-1:0] l);
        logic [63:0] s64;
        logic [31:0] l32;
        tok_t        t;
        s64      = 64'(s);
        l32      = 32'(l);
        t.kind   = k;
        t.start  = s64[31:0];
        t.length = l32[15:0];
        t.last   = 1'b0;
        return t;
    endfunction

    logic                     redo;
    logic                     e1_valid;
    logic                     e2_valid;
    tok_t                     e1;
    tok_t                     e2;
    lex_mode_t                m1;
    logic [POSITION_BITS-1:0] ots1;
    logic [LENGTH_BITS-1:0]   otl1;
    logic [2:0]               kw1;
    logic [1:0]               nf1;
    logic [LENGTH_BITS-1:0]   otl_inc;

    assign otl_inc = len_inc(otl);

    // First pass: the byte against the current mode
    always_comb
    begin
        m1       = mode;
        ots1     = ots;
        otl1     = otl;
        kw1      = kw;
        nf1      = nf;
        redo     = 1'b0;
        e1_valid = 1'b0;
        e1       = '0;
        case (mode)
            MODE_SLASH:
            begin
                if (byte_in == CH_SLASH) begin
                    m1 = MODE_LINE;
                end else if (byte_in == CH_STAR) begin
                    m1 = MODE_BLOCK;
                end else begin
                    e1_valid = 1'b1;
                    e1       = mk_tok(KIND_SLASH, ots, LENGTH_BITS'(1));
                    redo     = 1'b1;
                end
            end
            MODE_LINE:
            begin
                if (byte_in == CH_NUL || byte_in == CH_LF || byte_in == CH_CR)
                    redo = 1'b1;
            end
            MODE_BLOCK:
            begin
                if (byte_in == CH_NUL)
                    redo = 1'b1;
                else if (byte_in == CH_STAR)
                    m1 = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR:
            begin
                if (byte_in == CH_NUL)
                    redo = 1'b1;
                else if (byte_in == CH_SLASH)
                    m1 = MODE_IDLE;
                else if (byte_in != CH_STAR)
                    m1 = MODE_BLOCK;
            end
            MODE_MINUS:
            begin
                e1_valid = 1'b1;
                if (byte_in == CH_GT) begin
                    e1 = mk_tok(KIND_ARROW, ots, LENGTH_BITS'(2));
                    m1 = MODE_IDLE;
                end else begin
                    e1   = mk_tok(KIND_MINUS, ots, LENGTH_BITS'(1));
                    redo = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (is_alpha(byte_in) || is_digit(byte_in) || byte_in == CH_UNDER) begin
                    kw1  = kw_filter(kw, otl, byte_in);
                    otl1 = otl_inc;
                end else begin
                    e1_valid = 1'b1;
                    e1       = mk_tok(ident_kind(kw, otl), ots, otl);
                    redo     = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (nf[1]) begin
                    // byte after a repeated point is absorbed
                    if (byte_in == CH_NUL) begin
                        e1_valid = 1'b1;
                        e1       = mk_tok(KIND_NUMBER, ots, otl);
                        redo     = 1'b1;
                    end else begin
                        otl1 = otl_inc;
                        nf1  = {1'b0, nf[0]};
                    end
                end else if (is_digit(byte_in)) begin
                    otl1 = otl_inc;
                end else if (byte_in == CH_DOT) begin
                    otl1 = otl_inc;
                    nf1  = {nf[0], 1'b1};
                end else if (byte_in == CH_LOW_F) begin
                    otl1     = otl_inc;
                    e1_valid = 1'b1;
                    e1       = mk_tok(KIND_NUMBER, ots, otl_inc);
                    m1       = MODE_IDLE;
                end else begin
                    e1_valid = 1'b1;
                    e1       = mk_tok(KIND_NUMBER, ots, otl);
                    redo     = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (byte_in == CH_DQUOTE) begin
                    e1_valid = 1'b1;
                    e1       = mk_tok(KIND_STRING, ots, otl);
                    m1       = MODE_IDLE;
                end else if (byte_in == CH_NUL) begin
                    e1_valid = 1'b1;
                    e1       = mk_tok(KIND_STRING, ots, otl);
                    redo     = 1'b1;
                end else begin
                    otl1 = otl_inc;
                    if (byte_in == CH_BSLASH)
                        m1 = MODE_STRING_ESC;
                end
            end
            MODE_STRING_ESC:
            begin
                if (byte_in == CH_NUL) begin
                    e1_valid = 1'b1;
                    e1       = mk_tok(KIND_STRING, ots, otl);
                    redo     = 1'b1;
                end else begin
                    otl1 = otl_inc;
                    m1   = MODE_STRING;
                end
            end
            MODE_CHAR_TEXT:
            begin
                e1_valid = 1'b1;
                if (byte_in == CH_NUL) begin
                    e1   = mk_tok(KIND_CHAR, pos, LENGTH_BITS'(0));
                    redo = 1'b1;
                end else begin
                    e1 = mk_tok(KIND_CHAR, pos, LENGTH_BITS'(1));
                    m1 = MODE_CHAR_SKIP;
                end
            end
            MODE_CHAR_SKIP:
            begin
                if (byte_in == CH_NUL)
                    redo = 1'b1;
                else
                    m1 = MODE_IDLE;
            end
            default:
            begin
                redo = 1'b1;
            end
        endcase
    end

    // Second pass: handle the byte afresh from idle
    always_comb
    begin
        mode_next = m1;
        ots_next  = ots1;
        otl_next  = otl1;
        kw_next   = kw1;
        nf_next   = nf1;
        end_seen  = 1'b0;
        e2_valid  = 1'b0;
        e2        = '0;
        if (redo) begin
            mode_next = MODE_IDLE;
            if (byte_in == CH_NUL) begin
                e2_valid = 1'b1;
                e2       = mk_tok(KIND_END, pos, LENGTH_BITS'(1));
                end_seen = 1'b1;
                ots_next = '0;
                otl_next = '0;
                kw_next  = 3'b111;
                nf_next  = 2'b00;
            end else if (byte_in == CH_SPACE || byte_in == CH_TAB ||
                         byte_in == CH_LF || byte_in == CH_CR) begin
                mode_next = MODE_IDLE;
            end else if (byte_in == CH_SLASH) begin
                mode_next = MODE_SLASH;
                ots_next  = pos;
            end else if (byte_in == CH_MINUS) begin
                mode_next = MODE_MINUS;
                ots_next  = pos;
            end else if (byte_in == CH_SQUOTE) begin
                mode_next = MODE_CHAR_TEXT;
            end else if (byte_in == CH_DQUOTE) begin
                mode_next = MODE_STRING;
                ots_next  = pos + 1'b1;
                otl_next  = '0;
            end else if (is_alpha(byte_in) || byte_in == CH_UNDER) begin
                mode_next = MODE_IDENT;
                ots_next  = pos;
                otl_next  = LENGTH_BITS'(1);
                kw_next   = kw_filter(3'b111, '0, byte_in);
            end else if (is_digit(byte_in)) begin
                mode_next = MODE_NUMBER;
                ots_next  = pos;
                otl_next  = LENGTH_BITS'(1);
                nf_next   = 2'b00;
            end else begin
                e2_valid = 1'b1;
                e2       = mk_tok(punct_kind(byte_in), pos, LENGTH_BITS'(1));
            end
        end
    end

    // Pack the tokens in order and mark the last one
    always_comb
    begin
        res_cnt = {1'b0, e1_valid} + {1'b0, e2_valid};
        tok0    = e1_valid ? e1 : e2;
        tok1    = e2;
        if (res_cnt == 2'd2)
            tok1.last = 1'b1;
        else
            tok0.last = 1'b1;
    end

endmodule

`default_nettype wire

// ----- design/clex_outq.sv -----
// Two-entry result queue that parts the lexer logic from the output channel.
// Uses clex_pkg for the token record.
`default_nettype none

module clex_outq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [1:0]     push_cnt,
    input  clex_pkg::tok_t push0,
    input  clex_pkg::tok_t push1,
    input  logic           pop,
    output logic [1:0]     count,
    output clex_pkg::tok_t head
);
    import clex_pkg::*;

    tok_t       q_reg [2];
    tok_t       q_next [2];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [1:0] base;

    // Shift out the popped word, then append the new ones behind what stays
    always_comb
    begin
        q_next[0] = pop ? q_reg[1] : q_reg[0];
        q_next[1] = q_reg[1];
        base      = cnt_reg - {1'b0, pop};
        if (push_cnt != 2'd0)
            q_next[base[0]] = push0;
        if (push_cnt == 2'd2)
            q_next[1] = push1;
        cnt_next = base + push_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

    assign count = cnt_reg;
    assign head  = q_reg[0];

endmodule

`default_nettype wire

// ----- design/c_style_token_lexer_unit.sv -----
// C-style token lexer: one source byte per word in, tokens out.
// A taken byte is held in the input register; its tokens then pass through the result queue to the outputs.
// Throughput: one byte per cycle while the output takes one token a cycle. A byte that yields
// two tokens leaves one extra token in the two-entry result queue; a later two-token byte that
// meets that extra token waits until the queue pops it, and a byte with no token drains it.
// Reset clears the lexer state, byte offset, input valid flag and queue count; no clearing pass.
`default_nettype none

module c_style_token_lexer_unit #(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  source_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  token_kind,
    output logic [31:0] token_start,
    output logic [15:0] token_length,
    output logic        run_last
);
    import clex_pkg::*;

    logic                     byte_valid_reg;
    logic                     byte_valid_next;
    logic [7:0]               byte_reg;
    lex_mode_t                mode_reg;
    lex_mode_t                mode_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [POSITION_BITS-1:0] ots_reg;
    logic [POSITION_BITS-1:0] ots_next;
    logic [LENGTH_BITS-1:0]   otl_reg;
    logic [LENGTH_BITS-1:0]   otl_next;
    logic [2:0]               kw_reg;
    logic [2:0]               kw_next;
    logic [1:0]               nf_reg;
    logic [1:0]               nf_next;
    logic                     end_seen;
    logic [1:0]               res_cnt;
    tok_t                     tok0;
    tok_t                     tok1;
    tok_t                     head;
    logic [1:0]               q_count;
    logic                     pop;
    logic [2:0]               room;
    logic                     step_fire;
    logic                     in_take;

    clex_step #(
        .POSITION_BITS(POSITION_BITS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_step (
        .byte_in  (byte_reg),
        .mode     (mode_reg),
        .pos      (pos_reg),
        .ots      (ots_reg),
        .otl      (otl_reg),
        .kw       (kw_reg),
        .nf       (nf_reg),
        .mode_next(mode_next),
        .ots_next (ots_next),
        .otl_next (otl_next),
        .kw_next  (kw_next),
        .nf_next  (nf_next),
        .end_seen (end_seen),
        .res_cnt  (res_cnt),
        .tok0     (tok0),
        .tok1     (tok1)
    );

    clex_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_cnt(step_fire ? res_cnt : 2'd0),
        .push0   (tok0),
        .push1   (tok1),
        .pop     (pop),
        .count   (q_count),
        .head    (head)
    );

    // Advance the held byte only when the queue has room for all its tokens
    assign pop       = out_valid && !out_stall;
    assign room      = 3'd2 - {1'b0, q_count} + {2'b00, pop};
    assign step_fire = byte_valid_reg && ({1'b0, res_cnt} <= room);
    assign in_stall  = byte_valid_reg && !step_fire;
    assign in_take   = in_valid && !in_stall;

    assign byte_valid_next = in_take ? 1'b1 : (step_fire ? 1'b0 : byte_valid_reg);
    assign pos_next        = end_seen ? '0 : pos_reg + 1'b1;

    // Hold the input byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else
            byte_valid_reg <= byte_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            byte_reg <= source_byte;
    end

    // Lexer state, updated once per processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            pos_reg  <= '0;
            ots_reg  <= '0;
            otl_reg  <= '0;
            kw_reg   <= 3'b111;
            nf_reg   <= 2'b00;
        end
        else if (step_fire)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            ots_reg  <= ots_next;
            otl_reg  <= otl_next;
            kw_reg   <= kw_next;
            nf_reg   <= nf_next;
        end
    end

    assign out_valid    = (q_count != 2'd0);
    assign token_kind   = head.kind;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign run_last     = head.last;

endmodule

`default_nettype wire
